>>> hw/rtl/ttu_pkg.sv
// Shared types and constants for the tagged text to UCS-2 decoder.
`default_nettype none

package ttu_pkg;

  // Decoder phase within one string.
  typedef enum logic [2:0] {
    PH_TAG,
    PH_LATIN,
    PH_U16,
    PH_U8,
    PH_SKIP
  } phase_t;

  // Encoding tags carried by the first byte of a string.
  localparam logic [7:0] TAG_LATIN1 = 8'h01;
  localparam logic [7:0] TAG_UTF16  = 8'h02;
  localparam logic [7:0] TAG_UTF8   = 8'h04;

  // Byte-order mark lead that selects little endian.
  localparam logic [7:0] BOM_LE_LEAD = 8'hFF;

  // UTF-8 lead byte ranges.
  localparam logic [7:0] U8_ASCII_MAX = 8'h7F;
  localparam logic [7:0] U8_LEAD2_MIN = 8'hC2;
  localparam logic [7:0] U8_LEAD2_MAX = 8'hDF;
  localparam logic [7:0] U8_LEAD3_MIN = 8'hE0;
  localparam logic [7:0] U8_LEAD3_MAX = 8'hEF;

  // Number of byte-order mark slot bytes after a UTF-16 tag.
  localparam logic [1:0] MARK_SLOTS = 2'd2;

  // Continuation counts.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  // Replacement character for bad tags and invalid leads.
  localparam logic [15:0] QMARK = 16'h003F;

  // One decoded result handed from the decoder to the output register.
  typedef struct packed {
    logic        emit;
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        string_end;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/ttu_if.sv
// Valid/ready channel interfaces for the raw byte input and the decoded unit output.
`default_nettype none

interface ttu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ttu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        string_end;

  modport source (output valid, output code_unit, output unit_valid, output string_end,
                  input ready);
  modport sink   (input valid, input code_unit, input unit_valid, input string_end,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ttu_in_stage.sv
// Input register stage: captures one byte beat and holds it until the decoder consumes it.
`default_nettype none

module ttu_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  input  wire logic       consume,
  output logic            held_valid,
  output logic [7:0]      held_data_byte,
  output logic            held_last_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       load;

  // The slot frees up in the same cycle its beat moves on.
  assign in_ready  = !valid_r || consume;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (consume ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign held_valid     = valid_r;
  assign held_data_byte = data_r;
  assign held_last_byte = last_r;

endmodule

`default_nettype wire

>>> hw/rtl/ttu_decode.sv
// Decoder state and the per-byte decode logic that turns one byte into at most one result.
`default_nettype none

module ttu_decode (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  output ttu_pkg::result_t     res
);
  import ttu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        order_r, order_nxt;
  logic [1:0]  mark_r, mark_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [15:0] partial_r, partial_nxt;
  logic        term_r, term_nxt;

  logic [15:0] u16_unit;
  logic        have;
  logic [15:0] unit;

  assign u16_unit = order_r ? {data_byte, held_r} : {held_r, data_byte};

  // Next state.
  always_comb begin
    phase_nxt   = phase_r;
    order_nxt   = order_r;
    mark_nxt    = mark_r;
    held_nxt    = held_r;
    pend_nxt    = pend_r;
    partial_nxt = partial_r;
    term_nxt    = term_r;
    if (step) begin
      case (phase_r)
        PH_TAG: begin
          if (data_byte == TAG_LATIN1) begin
            phase_nxt = PH_LATIN;
          end else if (data_byte == TAG_UTF16) begin
            phase_nxt = PH_U16;
          end else if (data_byte == TAG_UTF8) begin
            phase_nxt = PH_U8;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_LATIN: begin
          if (!term_r && data_byte == 8'h00) begin
            term_nxt = 1'b1;
          end
        end
        PH_U16: begin
          if (!term_r) begin
            if (mark_r < MARK_SLOTS) begin
              if (mark_r == 2'd0) begin
                order_nxt = (data_byte == BOM_LE_LEAD);
              end
              mark_nxt = mark_r + 2'd1;
            end else if (pend_r == PEND_NONE) begin
              held_nxt = data_byte;
              pend_nxt = PEND_ONE;
            end else begin
              pend_nxt = PEND_NONE;
              if (u16_unit == 16'h0000) begin
                term_nxt = 1'b1;
              end
            end
          end
        end
        PH_U8: begin
          if (!term_r) begin
            if (pend_r == PEND_NONE) begin
              if (data_byte == 8'h00) begin
                term_nxt = 1'b1;
              end else if (data_byte >= U8_LEAD2_MIN && data_byte <= U8_LEAD2_MAX) begin
                partial_nxt = {5'd0, data_byte[4:0], 6'd0};
                pend_nxt    = PEND_ONE;
              end else if (data_byte >= U8_LEAD3_MIN && data_byte <= U8_LEAD3_MAX) begin
                partial_nxt = {data_byte[3:0], 12'd0};
                pend_nxt    = PEND_TWO;
              end
            end else if (pend_r == PEND_TWO) begin
              partial_nxt = partial_r | {4'd0, data_byte[5:0], 6'd0};
              pend_nxt    = PEND_ONE;
            end else begin
              partial_nxt = 16'h0000;
              pend_nxt    = PEND_NONE;
            end
          end
        end
        default: begin
        end
      endcase
      // The end of a string returns everything to the reset picture.
      if (last_byte) begin
        phase_nxt   = PH_TAG;
        order_nxt   = 1'b0;
        mark_nxt    = 2'd0;
        held_nxt    = 8'h00;
        pend_nxt    = PEND_NONE;
        partial_nxt = 16'h0000;
        term_nxt    = 1'b0;
      end
    end
  end

  // Result for the byte at hand.
  always_comb begin
    have = 1'b0;
    unit = 16'h0000;
    case (phase_r)
      PH_TAG: begin
        if (data_byte != TAG_LATIN1 && data_byte != TAG_UTF16 && data_byte != TAG_UTF8) begin
          have = 1'b1;
          unit = QMARK;
        end
      end
      PH_LATIN: begin
        if (!term_r && data_byte != 8'h00) begin
          have = 1'b1;
          unit = {8'h00, data_byte};
        end
      end
      PH_U16: begin
        if (!term_r && mark_r >= MARK_SLOTS && pend_r != PEND_NONE &&
            u16_unit != 16'h0000) begin
          have = 1'b1;
          unit = u16_unit;
        end
      end
      PH_U8: begin
        if (!term_r) begin
          if (pend_r == PEND_NONE) begin
            if (data_byte != 8'h00 && data_byte <= U8_ASCII_MAX) begin
              have = 1'b1;
              unit = {8'h00, data_byte};
            end else if (data_byte > U8_ASCII_MAX &&
                         !(data_byte >= U8_LEAD2_MIN && data_byte <= U8_LEAD3_MAX)) begin
              have = 1'b1;
              unit = QMARK;
            end
          end else if (pend_r != PEND_TWO) begin
            have = 1'b1;
            unit = partial_r | {10'd0, data_byte[5:0]};
          end
        end
      end
      default: begin
      end
    endcase
    res.emit       = have || last_byte;
    res.code_unit  = unit;
    res.unit_valid = have;
    res.string_end = last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TAG;
      order_r   <= 1'b0;
      mark_r    <= 2'd0;
      held_r    <= 8'h00;
      pend_r    <= PEND_NONE;
      partial_r <= 16'h0000;
      term_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      order_r   <= order_nxt;
      mark_r    <= mark_nxt;
      held_r    <= held_nxt;
      pend_r    <= pend_nxt;
      partial_r <= partial_nxt;
      term_r    <= term_nxt;
    end
  end

  // A string's last byte leaves the decoder waiting for a fresh tag.
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> phase_r == PH_TAG && pend_r == PEND_NONE && mark_r == 2'd0 &&
                          !term_r && !order_r)
    else $error("decoder state not cleared after last byte");

  // Continuation bookkeeping only exists inside a UTF-16 or UTF-8 string.
  a_pend_phase: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != PEND_NONE |-> phase_r == PH_U16 || phase_r == PH_U8)
    else $error("pending bytes outside a multi-byte encoding");

  // Termination is only reachable once a tag has been decoded.
  a_term_phase: assert property (@(posedge clk) disable iff (!rst_n)
    term_r |-> phase_r == PH_LATIN || phase_r == PH_U16 || phase_r == PH_U8)
    else $error("terminated flag set outside a decoding phase");

  // UTF-16 pairs only start after the whole mark slot has been consumed.
  a_mark_before_pair: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_U16 && pend_r != PEND_NONE |-> mark_r == MARK_SLOTS)
    else $error("UTF-16 pair started inside the mark slot");

endmodule

`default_nettype wire

>>> hw/rtl/ttu_out_stage.sv
// Output register stage: holds one decoded result until the receiver takes it.
`default_nettype none

module ttu_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  ttu_pkg::result_t      res,
  output logic                  can_take,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [15:0]           out_code_unit,
  output logic                  out_unit_valid,
  output logic                  out_string_end
);
  import ttu_pkg::*;

  logic        valid_r, valid_nxt;
  logic [15:0] unit_r;
  logic        uvalid_r;
  logic        end_r;

  // Room exists when empty or when the held beat leaves this cycle.
  assign can_take  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : ((valid_r && out_ready) ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_r   <= res.code_unit;
      uvalid_r <= res.unit_valid;
      end_r    <= res.string_end;
    end
  end

  assign out_valid      = valid_r;
  assign out_code_unit  = unit_r;
  assign out_unit_valid = uvalid_r;
  assign out_string_end = end_r;

endmodule

`default_nettype wire

>>> hw/rtl/tagged_text_to_ucs2_decoder_unit.sv
// Top level of the tagged text to UCS-2 decoder: input register, decoder and output register.
//
// Usage: strings arrive on in_chan one byte per beat. The first byte of each
// string is an encoding tag (1 Latin-1, 2 UTF-16 behind a two-byte byte-order mark slot,
// 4 UTF-8 of up to three bytes; any other tag yields one '?'). last_byte marks
// the final byte of a string, and the following byte is again a tag.
// out_chan carries one beat per completed character, plus one beat on every
// last byte; on that beat string_end is 1 and unit_valid tells whether
// code_unit holds a character completed by that byte. Bytes that complete
// nothing and are not last produce no output beat.
// A byte accepted into the input register is decoded combinationally and its result
// enters the result register once there is room: two registers (input register, then
// result register). Throughput: one byte per cycle while the receiver does not stall,
// set by the combinational decode between the two registers.
// Reset (rst_n low, synchronous) empties both registers and puts the decoder
// back to waiting for a tag with big endian and no pending bytes.
// When the receiver stalls, the result register holds its beat; the input
// register then holds its byte, and in_chan.ready drops only once both are
// full, so during a stall the two registers buffer at most one result and one byte.
`default_nettype none

module tagged_text_to_ucs2_decoder_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ttu_in_if.sink     in_chan,
  ttu_out_if.source  out_chan
);
  import ttu_pkg::*;

  logic       held_valid;
  logic [7:0] held_data_byte;
  logic       held_last_byte;
  logic       consume;
  logic       can_take;
  logic       load_out;
  result_t    res;

  ttu_in_stage u_in_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_data_byte   (in_chan.data_byte),
    .in_last_byte   (in_chan.last_byte),
    .consume        (consume),
    .held_valid     (held_valid),
    .held_data_byte (held_data_byte),
    .held_last_byte (held_last_byte)
  );

  // A held byte is decoded as soon as the result register has room, whether
  // or not it produces a beat; the decoder state advances with it.
  assign consume  = held_valid && can_take;
  assign load_out = consume && res.emit;

  ttu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (consume),
    .data_byte (held_data_byte),
    .last_byte (held_last_byte),
    .res       (res)
  );

  ttu_out_stage u_out_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load_out),
    .res            (res),
    .can_take       (can_take),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_code_unit  (out_chan.code_unit),
    .out_unit_valid (out_chan.unit_valid),
    .out_string_end (out_chan.string_end)
  );

  // Every last byte yields a beat with string_end set on the following cycle.
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    consume && held_last_byte |=> out_chan.valid && out_chan.string_end)
    else $error("last byte did not produce an end-of-string beat");

  // A beat with no character must be an end-of-string beat.
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.unit_valid |-> out_chan.string_end)
    else $error("empty result beat without string end");

  // A result beat only ever enters when room exists.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_chan.valid || out_chan.ready)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
